FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on clk_i, off while rst_ni is low.
`define TSB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form of the above.
`define TSB_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

FILE: design/tsb_pkg.sv
package tsb_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned COORD_BITS_DEF  = 24;
  localparam int unsigned THR_W           = 26;
  localparam int unsigned CFG_W           = 24;
  localparam int unsigned CAP_W           = 7;
  localparam int unsigned REG_IDX_W       = 3;
  localparam int unsigned TIER_W          = 2;
  localparam int unsigned IDX_OUT_W       = 6;
  localparam int unsigned CNT_OUT_W       = 7;

  localparam logic [THR_W-1:0] ONE_FIX = THR_W'(256);

  typedef enum logic [1:0] {
    TIER_NEAR = 2'd0,
    TIER_MID  = 2'd1,
    TIER_FAR  = 2'd2
  } tier_e;

  typedef enum logic [2:0] {
    REG_NEAR_ENTER   = 3'd0,
    REG_NEAR_EXIT    = 3'd1,
    REG_MIDDLE_ENTER = 3'd2,
    REG_MIDDLE_EXIT  = 3'd3,
    REG_NEAR_CAP     = 3'd4,
    REG_MIDDLE_CAP   = 3'd5,
    REG_TOTAL_CAP    = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQZ,
    ST_WR,
    ST_THR,
    ST_CH,
    ST_RI,
    ST_RD,
    ST_SC,
    ST_ER,
    ST_EW
  } state_e;

  typedef enum logic [1:0] {
    PASS_NEAR,
    PASS_MID,
    PASS_TOT
  } pass_e;

endpackage

FILE: design/tsb_ram.sv
module tsb_ram #(
  parameter int unsigned DEPTH = tsb_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned WIDTH = tsb_pkg::TIER_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tsb_square.sv
module tsb_square #(
  parameter int unsigned W = tsb_pkg::THR_W
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  output logic [2*W-1:0] prod_o
);

  logic [2*W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * a_i;
  end

  assign prod_o = prod_q;

endmodule

FILE: design/tier_select_with_budget_unit.sv
// channel | direction | handshake                | payload
// in      | sink      | in_valid_i / in_stall_o  | offset_x_i, offset_z_i, current_tier_i,
//         |           |                          | end_of_frame_i
// out     | source    | out_valid_o / out_stall_i| entry_index_o .. far_count_o
// cfg     | sink      | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// Load: each word steps through ST_SQX, ST_SQZ and ST_WR (one shared squarer, used for x then z).
// End of frame (n entries): the threshold chain (ST_THR), a tier pass (ST_CH), then three
// rank passes that visit each entry through ST_RI, ST_RD and ST_SC, with a rank scan over
// the distance memory (single read port) for each entry that needs one.
// Results: each word passes ST_ER and ST_EW and is held while out_stall_i is high.
// Reset clears control and config; the entry memories are not cleared.
`include "assert_macros.svh"

module tier_select_with_budget_unit #(
  parameter int unsigned MAX_ENTRIES = tsb_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned COORD_BITS  = tsb_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [COORD_BITS-1:0]     offset_x_i,
  input  logic signed [COORD_BITS-1:0]     offset_z_i,
  input  logic [1:0]                       current_tier_i,
  input  logic                             end_of_frame_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tsb_pkg::IDX_OUT_W-1:0]    entry_index_o,
  output logic [1:0]                       new_tier_o,
  output logic                             despawn_o,
  output logic                             last_result_o,
  output logic [tsb_pkg::CNT_OUT_W-1:0]    active_total_o,
  output logic [tsb_pkg::CNT_OUT_W-1:0]    near_count_o,
  output logic [tsb_pkg::CNT_OUT_W-1:0]    middle_count_o,
  output logic [tsb_pkg::CNT_OUT_W-1:0]    far_count_o,
  input  logic                             cfg_we_i,
  input  logic [tsb_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tsb_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned IW    = $clog2(MAX_ENTRIES);
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DW    = 2 * COORD_BITS + 1;
  localparam int unsigned MW    = (COORD_BITS > tsb_pkg::THR_W) ? COORD_BITS : tsb_pkg::THR_W;
  localparam int unsigned PW    = 2 * MW;
  localparam int unsigned KW    = (DW > PW) ? DW : PW;
  localparam int unsigned SW    = ((CW > tsb_pkg::CAP_W) ? CW : tsb_pkg::CAP_W) + 1;
  localparam int unsigned MEMW  = DW + tsb_pkg::TIER_W;
  localparam int unsigned TW    = tsb_pkg::THR_W;

  // config
  logic [tsb_pkg::CFG_W-1:0] near_enter_q, near_exit_q, middle_enter_q, middle_exit_q;
  logic [tsb_pkg::CAP_W-1:0] near_cap_q, middle_cap_q, total_cap_q;

  tsb_pkg::state_e state_q, state_d;
  tsb_pkg::pass_e  pass_q, pass_d;

  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, ridx_q, ridx_d, rank_q, rank_d;
  logic          rv_q, rv_d, eof_q, eof_d;
  logic [COORD_BITS-1:0] ax_q, ax_d, az_q, az_d;
  logic [1:0]    told_q, told_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [2:0]    k_q, k_d;
  logic [TW-1:0] prev_q, prev_d, cur;
  logic [PW-1:0] ne2_q, ne2_d, nx2_q, nx2_d, me2_q, me2_d, mx2_q, mx2_d;
  logic [DW-1:0] di_q, di_d;
  tsb_pkg::tier_e ti_q, ti_d;
  logic [CW-1:0] mid0_q, mid0_d, cf_q, cf_d, cm_q, cm_d;
  logic [CW-1:0] act_q, act_d, nn_q, nn_d, fn_q, fn_d;

  // datapath
  logic [MW-1:0]   mul_a;
  logic [PW-1:0]   prod;
  logic [IW-1:0]   raddr;
  logic [MEMW-1:0] dm_rd;
  logic [DW-1:0]   d_rd;
  logic [1:0]      told_rd, ta_rd, tb_rd, tc_rd, tsrc;
  logic            dp_rd;
  logic            lt_ne, gt_nx, lt_me, gt_mx;
  tsb_pkg::tier_e  ch_tier, res_tier;
  logic            res_desp, need, dec, ahead, ta_we, tb_we, tc_we, dp_we;
  logic [SW-1:0]   rank_s, ncap_s, mcap_s, tcap_s, mid0_s, n_s, base_s, rem_s;

  tsb_square #(.W(MW)) u_square (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .prod_o (prod)
  );

  tsb_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(MEMW)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == tsb_pkg::ST_WR),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({DW'(acc_q) + DW'(prod), told_q}),
    .raddr_i (raddr),
    .rdata_o (dm_rd)
  );

  tsb_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(tsb_pkg::TIER_W)) u_ta_ram (
    .clk_i (clk_i), .we_i (ta_we), .waddr_i (ridx_q[IW-1:0]), .wdata_i (ch_tier),
    .raddr_i (raddr), .rdata_o (ta_rd)
  );

  tsb_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(tsb_pkg::TIER_W)) u_tb_ram (
    .clk_i (clk_i), .we_i (tb_we), .waddr_i (i_q[IW-1:0]), .wdata_i (res_tier),
    .raddr_i (raddr), .rdata_o (tb_rd)
  );

  tsb_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(tsb_pkg::TIER_W)) u_tc_ram (
    .clk_i (clk_i), .we_i (tc_we), .waddr_i (i_q[IW-1:0]), .wdata_i (res_tier),
    .raddr_i (raddr), .rdata_o (tc_rd)
  );

  tsb_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(1)) u_dp_ram (
    .clk_i (clk_i), .we_i (dp_we), .waddr_i (i_q[IW-1:0]), .wdata_i (res_desp),
    .raddr_i (raddr), .rdata_o (dp_rd)
  );

  assign d_rd    = dm_rd[MEMW-1:tsb_pkg::TIER_W];
  assign told_rd = dm_rd[tsb_pkg::TIER_W-1:0];

  assign lt_ne = KW'(d_rd) < KW'(ne2_q);
  assign gt_nx = KW'(d_rd) > KW'(nx2_q);
  assign lt_me = KW'(d_rd) < KW'(me2_q);
  assign gt_mx = KW'(d_rd) > KW'(mx2_q);

  always_comb begin
    case (told_rd)
      tsb_pkg::TIER_NEAR:
        ch_tier = gt_nx ? (lt_me ? tsb_pkg::TIER_MID : tsb_pkg::TIER_FAR) : tsb_pkg::TIER_NEAR;
      tsb_pkg::TIER_MID:
        ch_tier = lt_ne ? tsb_pkg::TIER_NEAR : (gt_mx ? tsb_pkg::TIER_FAR : tsb_pkg::TIER_MID);
      default:
        ch_tier = lt_ne ? tsb_pkg::TIER_NEAR : (lt_me ? tsb_pkg::TIER_MID : tsb_pkg::TIER_FAR);
    endcase
  end

  // threshold clamp chain, one step per cycle
  always_comb begin
    case (k_q)
      3'd0: cur = TW'(near_enter_q);
      3'd1: cur = (TW'(near_exit_q) < prev_q + tsb_pkg::ONE_FIX) ?
                  prev_q + tsb_pkg::ONE_FIX : TW'(near_exit_q);
      3'd2: cur = (TW'(middle_enter_q) < prev_q + tsb_pkg::ONE_FIX) ?
                  prev_q + tsb_pkg::ONE_FIX : TW'(middle_enter_q);
      3'd3: cur = (TW'(middle_exit_q) < prev_q + tsb_pkg::ONE_FIX) ?
                  prev_q + tsb_pkg::ONE_FIX : TW'(middle_exit_q);
      default: cur = prev_q;
    endcase
  end

  always_comb begin
    case (state_q)
      tsb_pkg::ST_SQX: mul_a = MW'(ax_q);
      tsb_pkg::ST_SQZ: mul_a = MW'(az_q);
      tsb_pkg::ST_THR: mul_a = MW'(cur);
      default:         mul_a = '0;
    endcase
  end

  always_comb begin
    case (state_q)
      tsb_pkg::ST_CH, tsb_pkg::ST_SC: raddr = j_q[IW-1:0];
      default:                        raddr = i_q[IW-1:0];
    endcase
  end

  always_comb begin
    case (pass_q)
      tsb_pkg::PASS_NEAR: tsrc = ta_rd;
      tsb_pkg::PASS_MID:  tsrc = tb_rd;
      default:            tsrc = tc_rd;
    endcase
  end

  assign rank_s = SW'(rank_q);
  assign ncap_s = SW'(near_cap_q);
  assign mcap_s = SW'(middle_cap_q);
  assign tcap_s = SW'(total_cap_q);
  assign mid0_s = SW'(mid0_q);
  assign n_s    = SW'(cnt_q);
  assign rem_s  = n_s - tcap_s;

  always_comb begin
    case (ti_q)
      tsb_pkg::TIER_FAR: base_s = '0;
      tsb_pkg::TIER_MID: base_s = SW'(cf_q);
      default:           base_s = SW'(cf_q) + SW'(cm_q);
    endcase
  end

  always_comb begin
    case (pass_q)
      tsb_pkg::PASS_NEAR: need = (near_cap_q != '0) && (ti_q == tsb_pkg::TIER_NEAR);
      tsb_pkg::PASS_MID:  need = (middle_cap_q != '0) && (ti_q == tsb_pkg::TIER_MID);
      default:            need = (total_cap_q != '0) && (n_s > tcap_s);
    endcase
  end

  // entry j ranks ahead of entry i in this pass's order
  always_comb begin
    if (pass_q == tsb_pkg::PASS_TOT) begin
      ahead = (d_rd > di_q) || ((d_rd == di_q) && (ridx_q < i_q));
    end else begin
      ahead = (d_rd < di_q) || ((d_rd == di_q) && (ridx_q < i_q));
    end
  end

  always_comb begin
    res_tier = ti_q;
    res_desp = 1'b0;
    case (pass_q)
      tsb_pkg::PASS_NEAR: begin
        if (need && (rank_s >= ncap_s)) begin
          if ((middle_cap_q == '0) ||
              ((mid0_s < mcap_s) && ((rank_s - ncap_s) < (mcap_s - mid0_s)))) begin
            res_tier = tsb_pkg::TIER_MID;
          end else begin
            res_tier = tsb_pkg::TIER_FAR;
          end
        end
      end
      tsb_pkg::PASS_MID: begin
        if (need && (rank_s >= mcap_s)) begin
          res_tier = tsb_pkg::TIER_FAR;
        end
      end
      default: begin
        res_desp = need && ((rank_s + base_s) < rem_s);
      end
    endcase
  end

  assign dec   = (state_q == tsb_pkg::ST_SC) && (!need || ((j_q == cnt_q) && !rv_q));
  assign ta_we = (state_q == tsb_pkg::ST_CH) && rv_q;
  assign tb_we = dec && (pass_q == tsb_pkg::PASS_NEAR);
  assign tc_we = dec && (pass_q == tsb_pkg::PASS_MID);
  assign dp_we = dec && (pass_q == tsb_pkg::PASS_TOT);

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    ridx_d  = ridx_q;
    rank_d  = rank_q;
    rv_d    = 1'b0;
    eof_d   = eof_q;
    ax_d    = ax_q;
    az_d    = az_q;
    told_d  = told_q;
    acc_d   = acc_q;
    k_d     = k_q;
    prev_d  = prev_q;
    ne2_d   = ne2_q;
    nx2_d   = nx2_q;
    me2_d   = me2_q;
    mx2_d   = mx2_q;
    di_d    = di_q;
    ti_d    = ti_q;
    mid0_d  = mid0_q;
    cf_d    = cf_q;
    cm_d    = cm_q;
    act_d   = act_q;
    nn_d    = nn_q;
    fn_d    = fn_q;
    case (state_q)
      tsb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ax_d   = offset_x_i[COORD_BITS-1] ? (~offset_x_i + 1'b1) : offset_x_i;
          az_d   = offset_z_i[COORD_BITS-1] ? (~offset_z_i + 1'b1) : offset_z_i;
          told_d = current_tier_i;
          eof_d  = end_of_frame_i;
          k_d    = '0;
          if (cnt_q < CW'(MAX_ENTRIES)) begin
            state_d = tsb_pkg::ST_SQX;
          end else if (end_of_frame_i) begin
            state_d = tsb_pkg::ST_THR;
          end
        end
      end
      tsb_pkg::ST_SQX: state_d = tsb_pkg::ST_SQZ;
      tsb_pkg::ST_SQZ: begin
        acc_d   = prod;
        state_d = tsb_pkg::ST_WR;
      end
      tsb_pkg::ST_WR: begin
        cnt_d   = cnt_q + CW'(1);
        state_d = eof_q ? tsb_pkg::ST_THR : tsb_pkg::ST_IDLE;
      end
      tsb_pkg::ST_THR: begin
        prev_d = cur;
        k_d    = k_q + 3'd1;
        case (k_q)
          3'd0: begin
            mid0_d = '0;
            cf_d   = '0;
            cm_d   = '0;
            act_d  = '0;
            nn_d   = '0;
            fn_d   = '0;
          end
          3'd1: ne2_d = prod;
          3'd2: nx2_d = prod;
          3'd3: me2_d = prod;
          default: begin
            mx2_d   = prod;
            j_d     = '0;
            state_d = tsb_pkg::ST_CH;
          end
        endcase
      end
      tsb_pkg::ST_CH: begin
        if (j_q < cnt_q) begin
          rv_d   = 1'b1;
          ridx_d = j_q;
          j_d    = j_q + CW'(1);
        end
        if (rv_q && (ch_tier == tsb_pkg::TIER_MID)) begin
          mid0_d = mid0_q + CW'(1);
        end
        if ((j_q == cnt_q) && !rv_q) begin
          pass_d  = tsb_pkg::PASS_NEAR;
          i_d     = '0;
          state_d = tsb_pkg::ST_RI;
        end
      end
      tsb_pkg::ST_RI: state_d = tsb_pkg::ST_RD;
      tsb_pkg::ST_RD: begin
        di_d    = d_rd;
        ti_d    = tsb_pkg::tier_e'(tsrc);
        j_d     = '0;
        rank_d  = '0;
        state_d = tsb_pkg::ST_SC;
      end
      tsb_pkg::ST_SC: begin
        if (need && (j_q < cnt_q)) begin
          rv_d   = 1'b1;
          ridx_d = j_q;
          j_d    = j_q + CW'(1);
        end
        if (rv_q && (tsrc == ti_q) && ahead) begin
          rank_d = rank_q + CW'(1);
        end
        if (dec) begin
          if (pass_q == tsb_pkg::PASS_MID) begin
            if (res_tier == tsb_pkg::TIER_FAR) begin
              cf_d = cf_q + CW'(1);
            end else if (res_tier == tsb_pkg::TIER_MID) begin
              cm_d = cm_q + CW'(1);
            end
          end
          if ((pass_q == tsb_pkg::PASS_TOT) && !res_desp) begin
            act_d = act_q + CW'(1);
            if (ti_q == tsb_pkg::TIER_NEAR) begin
              nn_d = nn_q + CW'(1);
            end else if (ti_q == tsb_pkg::TIER_FAR) begin
              fn_d = fn_q + CW'(1);
            end
          end
          if ((i_q + CW'(1)) == cnt_q) begin
            i_d = '0;
            case (pass_q)
              tsb_pkg::PASS_NEAR: begin
                pass_d  = tsb_pkg::PASS_MID;
                state_d = tsb_pkg::ST_RI;
              end
              tsb_pkg::PASS_MID: begin
                pass_d  = tsb_pkg::PASS_TOT;
                state_d = tsb_pkg::ST_RI;
              end
              default: state_d = tsb_pkg::ST_ER;
            endcase
          end else begin
            i_d     = i_q + CW'(1);
            state_d = tsb_pkg::ST_RI;
          end
        end
      end
      tsb_pkg::ST_ER: state_d = tsb_pkg::ST_EW;
      tsb_pkg::ST_EW: begin
        if (!out_stall_i) begin
          if ((i_q + CW'(1)) == cnt_q) begin
            cnt_d   = '0;
            i_d     = '0;
            state_d = tsb_pkg::ST_IDLE;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = tsb_pkg::ST_ER;
          end
        end
      end
      default: state_d = tsb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsb_pkg::ST_IDLE;
      pass_q  <= tsb_pkg::PASS_NEAR;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      ridx_q  <= '0;
      rank_q  <= '0;
      rv_q    <= 1'b0;
      eof_q   <= 1'b0;
      k_q     <= '0;
      mid0_q  <= '0;
      cf_q    <= '0;
      cm_q    <= '0;
      act_q   <= '0;
      nn_q    <= '0;
      fn_q    <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      ridx_q  <= ridx_d;
      rank_q  <= rank_d;
      rv_q    <= rv_d;
      eof_q   <= eof_d;
      k_q     <= k_d;
      mid0_q  <= mid0_d;
      cf_q    <= cf_d;
      cm_q    <= cm_d;
      act_q   <= act_d;
      nn_q    <= nn_d;
      fn_q    <= fn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    az_q   <= az_d;
    told_q <= told_d;
    acc_q  <= acc_d;
    prev_q <= prev_d;
    ne2_q  <= ne2_d;
    nx2_q  <= nx2_d;
    me2_q  <= me2_d;
    mx2_q  <= mx2_d;
    di_q   <= di_d;
    ti_q   <= ti_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_enter_q   <= tsb_pkg::CFG_W'(10240);
      near_exit_q    <= tsb_pkg::CFG_W'(11520);
      middle_enter_q <= tsb_pkg::CFG_W'(30720);
      middle_exit_q  <= tsb_pkg::CFG_W'(33280);
      near_cap_q     <= '0;
      middle_cap_q   <= '0;
      total_cap_q    <= '0;
    end else if (cfg_we_i) begin
      case (tsb_pkg::reg_idx_e'(cfg_idx_i))
        tsb_pkg::REG_NEAR_ENTER:   near_enter_q   <= cfg_data_i;
        tsb_pkg::REG_NEAR_EXIT:    near_exit_q    <= cfg_data_i;
        tsb_pkg::REG_MIDDLE_ENTER: middle_enter_q <= cfg_data_i;
        tsb_pkg::REG_MIDDLE_EXIT:  middle_exit_q  <= cfg_data_i;
        tsb_pkg::REG_NEAR_CAP:     near_cap_q     <= cfg_data_i[tsb_pkg::CAP_W-1:0];
        tsb_pkg::REG_MIDDLE_CAP:   middle_cap_q   <= cfg_data_i[tsb_pkg::CAP_W-1:0];
        tsb_pkg::REG_TOTAL_CAP:    total_cap_q    <= cfg_data_i[tsb_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o     = (state_q != tsb_pkg::ST_IDLE);
  assign out_valid_o    = (state_q == tsb_pkg::ST_EW);
  assign entry_index_o  = tsb_pkg::IDX_OUT_W'(i_q);
  assign new_tier_o     = tc_rd;
  assign despawn_o      = dp_rd;
  assign last_result_o  = ((i_q + CW'(1)) == cnt_q);
  assign active_total_o = tsb_pkg::CNT_OUT_W'(act_q);
  assign near_count_o   = tsb_pkg::CNT_OUT_W'(nn_q);
  assign middle_count_o = tsb_pkg::CNT_OUT_W'(act_q - nn_q - fn_q);
  assign far_count_o    = tsb_pkg::CNT_OUT_W'(fn_q);

  `TSB_ASSERT_IMPL(a_no_load_while_emit, out_valid_o, in_stall_o, "input taken during results")
  `TSB_ASSERT(a_count_bound, cnt_q <= CW'(MAX_ENTRIES), "entry count past capacity")
  `TSB_ASSERT_IMPL(a_scan_bound, state_q == tsb_pkg::ST_SC, (j_q <= cnt_q) && (i_q < cnt_q),
                   "scan index past frame")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] z;
    logic [1:0]         tier;
    logic               eof;
  } entry_t;

  typedef struct {
    logic [5:0] idx;
    logic [1:0] tier;
    logic       desp;
    logic       last;
    logic [6:0] act;
    logic [6:0] nr;
    logic [6:0] md;
    logic [6:0] fr;
  } tier_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [23:0] offset_x_i = '0;
  logic signed [23:0] offset_z_i = '0;
  logic [1:0] current_tier_i = '0;
  logic end_of_frame_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [5:0] entry_index_o;
  logic [1:0] new_tier_o;
  logic despawn_o, last_result_o;
  logic [6:0] active_total_o, near_count_o, middle_count_o, far_count_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  tier_select_with_budget_unit dut (.*);

  initial forever #1 clk_i = ~clk_i;

  entry_t     pend_q[$];
  tier_word_t tier_word_q[$];
  int         mismatches = 0;

  // mirror of the register file
  longint unsigned thr_reg[4] = '{10240, 11520, 30720, 33280};
  int unsigned     near_cap = 0, mid_cap = 0, tot_cap = 0;

  // frame being loaded
  longint unsigned dist_mem[64];
  logic [1:0]      held_mem[64];
  logic [1:0]      pick_mem[64];
  bit              gone_mem[64];
  int unsigned     n_loaded = 0;
  int unsigned     order_list[64];

  function automatic longint unsigned mag(logic signed [23:0] v);
    logic [23:0] u;
    u = v[23] ? (~v + 24'd1) : v;
    return 64'(u);
  endfunction

  function automatic int unsigned rank_tier(logic [1:0] tr, bit desc);
    int unsigned m, j;
    bit later;
    m = 0;
    for (int unsigned i = 0; i < n_loaded; i++) begin
      if (pick_mem[i] != tr) continue;
      j = m;
      while (j > 0) begin
        later = desc ? (dist_mem[order_list[j-1]] < dist_mem[i])
                     : (dist_mem[order_list[j-1]] > dist_mem[i]);
        if (!later) break;
        order_list[j] = order_list[j-1];
        j--;
      end
      order_list[j] = i;
      m++;
    end
    return m;
  endfunction

  function automatic void predict_frame();
    longint unsigned ne, nx, me, mx, ne2, nx2, me2, mx2, d;
    int unsigned mid_n, m, drop, act, nr, fr;
    tier_word_t w;
    ne = thr_reg[0];
    nx = thr_reg[1]; if (nx < ne + 256) nx = ne + 256;
    me = thr_reg[2]; if (me < nx + 256) me = nx + 256;
    mx = thr_reg[3]; if (mx < me + 256) mx = me + 256;
    ne2 = ne * ne; nx2 = nx * nx; me2 = me * me; mx2 = mx * mx;
    mid_n = 0;
    for (int unsigned i = 0; i < n_loaded; i++) begin
      d = dist_mem[i];
      if (held_mem[i] == tsb_pkg::TIER_NEAR)
        pick_mem[i] = (d > nx2) ? ((d < me2) ? tsb_pkg::TIER_MID : tsb_pkg::TIER_FAR)
                                : tsb_pkg::TIER_NEAR;
      else if (held_mem[i] == tsb_pkg::TIER_MID)
        pick_mem[i] = (d < ne2) ? tsb_pkg::TIER_NEAR
                                : ((d > mx2) ? tsb_pkg::TIER_FAR : tsb_pkg::TIER_MID);
      else
        pick_mem[i] = (d < ne2) ? tsb_pkg::TIER_NEAR
                                : ((d < me2) ? tsb_pkg::TIER_MID : tsb_pkg::TIER_FAR);
      gone_mem[i] = 0;
      if (pick_mem[i] == tsb_pkg::TIER_MID) mid_n++;
    end
    if (near_cap > 0) begin
      m = rank_tier(tsb_pkg::TIER_NEAR, 0);
      for (int unsigned i = near_cap; i < m; i++) begin
        if (mid_cap == 0 || mid_n < mid_cap) begin
          pick_mem[order_list[i]] = tsb_pkg::TIER_MID;
          mid_n++;
        end else begin
          pick_mem[order_list[i]] = tsb_pkg::TIER_FAR;
        end
      end
    end
    if (mid_cap > 0) begin
      m = rank_tier(tsb_pkg::TIER_MID, 0);
      for (int unsigned i = mid_cap; i < m; i++) pick_mem[order_list[i]] = tsb_pkg::TIER_FAR;
    end
    if (tot_cap > 0 && n_loaded > tot_cap) begin
      drop = n_loaded - tot_cap;
      for (int t = 2; t >= 0 && drop > 0; t--) begin
        m = rank_tier(t[1:0], 1);
        for (int unsigned i = 0; i < m && drop > 0; i++) begin
          gone_mem[order_list[i]] = 1;
          drop--;
        end
      end
    end
    act = 0; nr = 0; fr = 0;
    for (int unsigned i = 0; i < n_loaded; i++) begin
      if (gone_mem[i]) continue;
      act++;
      if (pick_mem[i] == tsb_pkg::TIER_NEAR) nr++;
      if (pick_mem[i] == tsb_pkg::TIER_FAR) fr++;
    end
    for (int unsigned i = 0; i < n_loaded; i++) begin
      w.idx = i[5:0]; w.tier = pick_mem[i]; w.desp = gone_mem[i];
      w.last = (i + 1 == n_loaded); w.act = act[6:0]; w.nr = nr[6:0];
      w.md = 7'(act - nr - fr); w.fr = fr[6:0];
      tier_word_q = {tier_word_q, w};
    end
    n_loaded = 0;
  endfunction

  // sender
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    entry_t e;
    if (in_valid_i && !in_stall_o) begin
      if (n_loaded < 64) begin
        dist_mem[n_loaded] = mag(offset_x_i) * mag(offset_x_i) +
                             mag(offset_z_i) * mag(offset_z_i);
        held_mem[n_loaded] = (current_tier_i == 2'd3) ? tsb_pkg::TIER_FAR : current_tier_i;
        n_loaded++;
      end
      if (end_of_frame_i) predict_frame();
    end
    if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() > 0) begin
        e = pend_q.pop_front();
        offset_x_i <= e.x; offset_z_i <= e.z;
        current_tier_i <= e.tier; end_of_frame_i <= e.eof;
        in_valid_i <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  int stall_mode = 0, mode_left = 0, hold_left = 0, words_seen = 0;
  bit held_once = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) words_seen++;
    if (!held_once && words_seen >= 30 && pend_q.size() > 1) begin
      held_once = 1;
      hold_left = 600;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(10, 80);
    end else mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    tier_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tier_word_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word idx=%0d", entry_index_o);
      end else begin
        w = tier_word_q.pop_front();
        if (entry_index_o !== w.idx || new_tier_o !== w.tier || despawn_o !== w.desp ||
            last_result_o !== w.last || active_total_o !== w.act ||
            near_count_o !== w.nr || middle_count_o !== w.md || far_count_o !== w.fr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp idx%0d t%0d d%0d l%0d a%0d n%0d m%0d f%0d %s",
                     w.idx, w.tier, w.desp, w.last, w.act, w.nr, w.md, w.fr,
                     $sformatf("got idx%0d t%0d d%0d l%0d a%0d n%0d m%0d f%0d",
                     entry_index_o, new_tier_o, despawn_o, last_result_o,
                     active_total_o, near_count_o, middle_count_o, far_count_o));
        end
      end
    end
  end

  task automatic add(logic signed [23:0] x, logic signed [23:0] z, logic [1:0] t,
                     logic eof);
    entry_t e;
    e.x = x; e.z = z; e.tier = t; e.eof = eof;
    pend_q = {pend_q, e};
  endtask

  function automatic logic signed [23:0] rand_coord();
    logic signed [23:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = 24'($urandom());
      2: v = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: begin
        v = 24'($urandom_range(0, 40000));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic rand_frame(int n);
    for (int i = 0; i < n; i++)
      add(rand_coord(), rand_coord(), 2'($urandom_range(0, 3)), i == n - 1);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pend_q.size() > 0 || in_valid_i || tier_word_q.size() > 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(tsb_pkg::reg_idx_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tsb_pkg::REG_NEAR_ENTER:   thr_reg[0] = 64'(val);
      tsb_pkg::REG_NEAR_EXIT:    thr_reg[1] = 64'(val);
      tsb_pkg::REG_MIDDLE_ENTER: thr_reg[2] = 64'(val);
      tsb_pkg::REG_MIDDLE_EXIT:  thr_reg[3] = 64'(val);
      tsb_pkg::REG_NEAR_CAP:     near_cap = 32'(val[6:0]);
      tsb_pkg::REG_MIDDLE_CAP:   mid_cap = 32'(val[6:0]);
      tsb_pkg::REG_TOTAL_CAP:    tot_cap = 32'(val[6:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_thr();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 50000));
    endcase
  endfunction

  function automatic logic [23:0] rand_cap();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'd64;
      default: return 24'($urandom_range(1, 5));
    endcase
  endfunction

  initial begin
    int sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // default thresholds: extremes, tier code 3, hysteresis edges
    add(24'sh0, 24'sh0, tsb_pkg::TIER_NEAR, 0);
    add(24'sh7FFFFF, 24'sh7FFFFF, tsb_pkg::TIER_NEAR, 0);
    add(24'sh800000, 24'sh800000, tsb_pkg::TIER_MID, 0);
    add(24'sd10239, 24'sd0, tsb_pkg::TIER_FAR, 0);
    add(24'sd10240, 24'sd0, tsb_pkg::TIER_MID, 0);
    add(-24'sd11520, 24'sd0, tsb_pkg::TIER_NEAR, 0);
    add(24'sd0, 24'sd11521, tsb_pkg::TIER_NEAR, 0);
    add(24'sd30719, 24'sd0, 2'd3, 0);
    add(24'sd33280, 24'sd0, tsb_pkg::TIER_MID, 0);
    add(24'sd33281, 24'sd0, tsb_pkg::TIER_MID, 1);
    drain();
    write_reg(tsb_pkg::REG_NEAR_CAP, 24'd1);
    write_reg(tsb_pkg::REG_MIDDLE_CAP, 24'd2);
    write_reg(tsb_pkg::REG_TOTAL_CAP, 24'd3);
    write_reg(tsb_pkg::reg_idx_e'(3'd7), 24'hFFFFFF);
    add(24'sd100, 24'sd0, tsb_pkg::TIER_NEAR, 0);
    add(24'sd100, 24'sd0, tsb_pkg::TIER_FAR, 0);
    add(24'sd50, 24'sd0, tsb_pkg::TIER_MID, 0);
    add(24'sd20000, 24'sd0, tsb_pkg::TIER_FAR, 0);
    add(24'sd20000, 24'sd0, tsb_pkg::TIER_MID, 0);
    add(24'sd90000, 24'sd0, tsb_pkg::TIER_FAR, 0);
    add(24'sd90000, 24'sd1, 2'd3, 1);
    drain();
    write_reg(tsb_pkg::REG_NEAR_ENTER, 24'hFFFFFF);
    write_reg(tsb_pkg::REG_NEAR_EXIT, 24'd0);
    write_reg(tsb_pkg::REG_MIDDLE_ENTER, 24'd0);
    write_reg(tsb_pkg::REG_MIDDLE_EXIT, 24'd0);
    add(24'sh7FFFFF, 24'sh800000, tsb_pkg::TIER_FAR, 0);
    add(24'sd5, -24'sd5, tsb_pkg::TIER_MID, 1);
    drain();
    // random phases
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(tsb_pkg::REG_NEAR_ENTER, rand_thr());
      write_reg(tsb_pkg::REG_NEAR_EXIT, rand_thr());
      write_reg(tsb_pkg::REG_MIDDLE_ENTER, rand_thr());
      write_reg(tsb_pkg::REG_MIDDLE_EXIT, rand_thr());
      write_reg(tsb_pkg::REG_NEAR_CAP, rand_cap());
      write_reg(tsb_pkg::REG_MIDDLE_CAP, rand_cap());
      write_reg(tsb_pkg::REG_TOTAL_CAP, rand_cap());
      if (ph == 3) begin
        rand_frame(66);
        sent += 66;
      end
      for (int f = 0; f < 2; f++) begin
        int n;
        n = $urandom_range(1, 10);
        rand_frame(n);
        sent += n;
      end
      drain();
    end
    if (mismatches == 0 && tier_word_q.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/tsb_pkg.sv
design/tsb_ram.sv
design/tsb_square.sv
design/tier_select_with_budget_unit.sv
bench/tb_top.sv
